@@ design/ppft_pkg.sv @@
package ppft_pkg;

  // Field widths
  localparam int COORD_WIDTH = 32;
  localparam int ANGLE_WIDTH = 16;
  localparam int TRIG_WIDTH  = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;

  // CORDIC depth, capped by the arctangent table
  localparam int TRIG_STAGES   = 16;
  localparam int ATAN_COUNT    = 24;
  localparam int CORDIC_STAGES = (TRIG_STAGES < ATAN_COUNT) ? TRIG_STAGES : ATAN_COUNT;

  // CORDIC datapath: Q2.30 with headroom for the unfolded heading
  localparam int CW          = 34;
  localparam int ANGLE_SHIFT = 33 - ANGLE_WIDTH;

  localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
  localparam logic signed [CW-1:0] Q30_PI   = 34'sd3373259426;
  localparam logic signed [CW-1:0] Q30_HPI  = 34'sd1686629713;

  localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = 16'sd16384;

  // atan(2^-i) in Q2.30
  localparam logic [CW-1:0] ATAN_Q30 [ATAN_COUNT] = '{
    34'd843314856, 34'd497837829, 34'd263043836, 34'd133525158,
    34'd67021686,  34'd33543515,  34'd16775850,  34'd8388437,
    34'd4194282,   34'd2097149,   34'd1048576,   34'd524287,
    34'd262143,    34'd131071,    34'd65535,     34'd32767,
    34'd16383,     34'd8191,      34'd4095,      34'd2047,
    34'd1023,      34'd511,       34'd255,       34'd127
  };

  // Coordinates that travel alongside the trig pipeline
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] qx;
    logic signed [COORD_WIDTH-1:0] qy;
    logic signed [DIFF_WIDTH-1:0]  dx;
    logic signed [DIFF_WIDTH-1:0]  dy;
  } coord_t;

  // Trig unit result with its valid bit
  typedef struct packed {
    logic                         valid;
    logic signed [TRIG_WIDTH-1:0] cos_val;
    logic signed [TRIG_WIDTH-1:0] sin_val;
  } trig_t;

endpackage

@@ design/ppft_cordic.sv @@
module ppft_cordic import ppft_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  input  coord_t                        coord_i,
  output trig_t                         trig_o,
  output coord_t                        coord_o
);

  // Pipeline registers: index 0 is the input stage
  logic                 valid_q [CORDIC_STAGES+1];
  logic                 neg_q   [CORDIC_STAGES+1];
  logic signed [CW-1:0] x_q     [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_q     [CORDIC_STAGES+1];
  logic signed [CW-1:0] z_q     [CORDIC_STAGES+1];
  coord_t               coord_q [CORDIC_STAGES+1];

  // Scale heading to Q2.30 and fold into the right half plane
  logic signed [CW-1:0] z_scaled;
  logic signed [CW-1:0] z0_d;
  logic                 neg0_d;

  assign z_scaled = CW'(angle_i) <<< ANGLE_SHIFT;

  always_comb begin
    z0_d   = z_scaled;
    neg0_d = 1'b0;
    if (z_scaled > Q30_HPI) begin
      z0_d   = z_scaled - Q30_PI;
      neg0_d = 1'b1;
    end else if (z_scaled < -Q30_HPI) begin
      z0_d   = z_scaled + Q30_PI;
      neg0_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      neg_q[0]   <= neg0_d;
      x_q[0]     <= GAIN_INV;
      y_q[0]     <= '0;
      z_q[0]     <= z0_d;
      coord_q[0] <= coord_i;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xs, ys, atan_v;
    logic signed [CW-1:0] x_d, y_d, z_d;

    assign xs     = x_q[i] >>> i;
    assign ys     = y_q[i] >>> i;
    assign atan_v = $signed(ATAN_Q30[i]);

    always_comb begin
      if (!z_q[i][CW-1]) begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_q[i] - atan_v;
      end else begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_q[i] + atan_v;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (valid_q[i]) begin
        x_q[i+1]     <= x_d;
        y_q[i+1]     <= y_d;
        z_q[i+1]     <= z_d;
        neg_q[i+1]   <= neg_q[i];
        coord_q[i+1] <= coord_q[i];
      end
    end
  end

  // Undo the fold, round Q2.30 to Q1.14 and clamp
  function automatic logic signed [TRIG_WIDTH-1:0] clamp_trig(input logic signed [CW:0] v);
    logic signed [CW:0] hi;
    logic signed [CW:0] lo;
    hi = (CW+1)'(TRIG_ONE);
    lo = -hi;
    if (v > hi) begin
      clamp_trig = TRIG_ONE;
    end else if (v < lo) begin
      clamp_trig = -TRIG_ONE;
    end else begin
      clamp_trig = TRIG_WIDTH'(v);
    end
  endfunction

  logic signed [CW-1:0] x_fin, y_fin;
  logic signed [CW:0]   x_rnd, y_rnd;

  assign x_fin = neg_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
  assign y_fin = neg_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
  assign x_rnd = ((CW+1)'(x_fin) + (CW+1)'(32768)) >>> 16;
  assign y_rnd = ((CW+1)'(y_fin) + (CW+1)'(32768)) >>> 16;

  logic                         out_valid_q;
  logic signed [TRIG_WIDTH-1:0] cos_q, sin_q;
  coord_t                       coord_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= valid_q[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q[CORDIC_STAGES]) begin
      cos_q       <= clamp_trig(x_rnd);
      sin_q       <= clamp_trig(y_rnd);
      coord_out_q <= coord_q[CORDIC_STAGES];
    end
  end

  assign trig_o.valid   = out_valid_q;
  assign trig_o.cos_val = cos_q;
  assign trig_o.sin_val = sin_q;
  assign coord_o        = coord_out_q;

endmodule

@@ design/planar_pose_frame_transform_core.sv @@
// Result: done_o and the outputs are driven from the saturate-stage registers.
// Throughput: one transaction per cycle; busy stays low; the input register, each CORDIC
//   stage, the trig rounding, multiply, sum and saturate stages are one register each.
// Reset: rst_ni clears all valid bits asynchronously; data registers are not reset.
module planar_pose_frame_transform_core import ppft_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] pose_x_i,
  input  logic signed [COORD_WIDTH-1:0] pose_y_i,
  input  logic signed [ANGLE_WIDTH-1:0] pose_heading_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] global_x_o,
  output logic signed [COORD_WIDTH-1:0] global_y_o,
  output logic signed [COORD_WIDTH-1:0] local_x_o,
  output logic signed [COORD_WIDTH-1:0] local_y_o,
  output logic signed [TRIG_WIDTH-1:0]  cos_heading_o,
  output logic signed [TRIG_WIDTH-1:0]  sin_heading_o
);

  localparam int LATENCY = CORDIC_STAGES + 5;
  localparam int PROD_W  = DIFF_WIDTH + TRIG_WIDTH;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RND_W   = SUM_W - 14;
  localparam int SAT_W   = RND_W + 1;

  localparam logic signed [SAT_W-1:0] SAT_HI =
    {{(SAT_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

  // Pipeline never stalls
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Differences for the world-to-robot transform, full width
  coord_t coord_in;
  assign coord_in.px = pose_x_i;
  assign coord_in.py = pose_y_i;
  assign coord_in.qx = point_x_i;
  assign coord_in.qy = point_y_i;
  assign coord_in.dx = DIFF_WIDTH'(point_x_i) - DIFF_WIDTH'(pose_x_i);
  assign coord_in.dy = DIFF_WIDTH'(point_y_i) - DIFF_WIDTH'(pose_y_i);

  // Trig unit
  trig_t  trig;
  coord_t coord;

  ppft_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i (pose_heading_i),
    .coord_i (coord_in),
    .trig_o  (trig),
    .coord_o (coord)
  );

  // Multiply stage
  logic                          mul_valid_q;
  logic signed [PROD_W-1:0]      qx_c_q, qy_s_q, qx_s_q, qy_c_q;
  logic signed [PROD_W-1:0]      dx_c_q, dy_s_q, dy_c_q, dx_s_q;
  logic signed [COORD_WIDTH-1:0] mul_px_q, mul_py_q;
  logic signed [TRIG_WIDTH-1:0]  mul_cos_q, mul_sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= trig.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (trig.valid) begin
      qx_c_q    <= PROD_W'(coord.qx) * PROD_W'(trig.cos_val);
      qy_s_q    <= PROD_W'(coord.qy) * PROD_W'(trig.sin_val);
      qx_s_q    <= PROD_W'(coord.qx) * PROD_W'(trig.sin_val);
      qy_c_q    <= PROD_W'(coord.qy) * PROD_W'(trig.cos_val);
      dx_c_q    <= PROD_W'(coord.dx) * PROD_W'(trig.cos_val);
      dy_s_q    <= PROD_W'(coord.dy) * PROD_W'(trig.sin_val);
      dy_c_q    <= PROD_W'(coord.dy) * PROD_W'(trig.cos_val);
      dx_s_q    <= PROD_W'(coord.dx) * PROD_W'(trig.sin_val);
      mul_px_q  <= coord.px;
      mul_py_q  <= coord.py;
      mul_cos_q <= trig.cos_val;
      mul_sin_q <= trig.sin_val;
    end
  end

  // Sum and round Q19.30 products back to Q16.16 (round half up)
  logic signed [SUM_W-1:0] gx_sum, gy_sum, lx_sum, ly_sum;
  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(8192);

  assign gx_sum = (SUM_W'(qx_c_q) - SUM_W'(qy_s_q) + HALF_LSB) >>> 14;
  assign gy_sum = (SUM_W'(qx_s_q) + SUM_W'(qy_c_q) + HALF_LSB) >>> 14;
  assign lx_sum = (SUM_W'(dx_c_q) + SUM_W'(dy_s_q) + HALF_LSB) >>> 14;
  assign ly_sum = (SUM_W'(dy_c_q) - SUM_W'(dx_s_q) + HALF_LSB) >>> 14;

  logic                          sum_valid_q;
  logic signed [RND_W-1:0]       gx_rnd_q, gy_rnd_q, lx_rnd_q, ly_rnd_q;
  logic signed [COORD_WIDTH-1:0] sum_px_q, sum_py_q;
  logic signed [TRIG_WIDTH-1:0]  sum_cos_q, sum_sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else begin
      sum_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid_q) begin
      gx_rnd_q  <= RND_W'(gx_sum);
      gy_rnd_q  <= RND_W'(gy_sum);
      lx_rnd_q  <= RND_W'(lx_sum);
      ly_rnd_q  <= RND_W'(ly_sum);
      sum_px_q  <= mul_px_q;
      sum_py_q  <= mul_py_q;
      sum_cos_q <= mul_cos_q;
      sum_sin_q <= mul_sin_q;
    end
  end

  // Add pose offset to the global results and saturate all four
  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      sat_coord = COORD_WIDTH'(SAT_HI);
    end else if (v < SAT_LO) begin
      sat_coord = COORD_WIDTH'(SAT_LO);
    end else begin
      sat_coord = COORD_WIDTH'(v);
    end
  endfunction

  logic signed [SAT_W-1:0] gx_full, gy_full;
  assign gx_full = SAT_W'(sum_px_q) + SAT_W'(gx_rnd_q);
  assign gy_full = SAT_W'(sum_py_q) + SAT_W'(gy_rnd_q);

  logic                          out_valid_q;
  logic signed [COORD_WIDTH-1:0] gx_q, gy_q, lx_q, ly_q;
  logic signed [TRIG_WIDTH-1:0]  cos_q, sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_valid_q) begin
      gx_q  <= sat_coord(gx_full);
      gy_q  <= sat_coord(gy_full);
      lx_q  <= sat_coord(SAT_W'(lx_rnd_q));
      ly_q  <= sat_coord(SAT_W'(ly_rnd_q));
      cos_q <= sum_cos_q;
      sin_q <= sum_sin_q;
    end
  end

  assign done_o        = out_valid_q;
  assign global_x_o    = gx_q;
  assign global_y_o    = gy_q;
  assign local_x_o     = lx_q;
  assign local_y_o     = ly_q;
  assign cos_heading_o = cos_q;
  assign sin_heading_o = sin_q;

`ifndef SYNTH
  // Every accepted transaction is strobed after the fixed latency
  a_latency_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("result missing after fixed latency");

  // No strobe without a matching earlier accepted transaction
  a_latency_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##LATENCY !done_o)
    else $error("spurious result strobe");

  // Trig outputs stay within the unit range
  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cos_heading_o <= TRIG_ONE) && (cos_heading_o >= -TRIG_ONE) &&
               (sin_heading_o <= TRIG_ONE) && (sin_heading_o >= -TRIG_ONE))
    else $error("trig output out of range");
`endif

endmodule
